### hw/rtl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants for the delta-list timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dltq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      FUNC_ADVANCE   = 2'd0,
      FUNC_INSERT    = 2'd1,
      FUNC_RM_OWNER  = 2'd2,
      FUNC_RM_VALUE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_EXPIRED = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_FULL    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] elapsed;
      logic [31:0] delay;
      logic [31:0] period;
      logic [7:0]  owner;
      logic [31:0] user_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  owner_out;
      logic [31:0] value_out;
      logic [31:0] time_out;
      logic [31:0] next_delay;
      logic [4:0]  entry_count;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_WALK,
      S_INS_PLACE,
      S_ADV_WALK,
      S_EXP_SCAN,
      S_POP_CHK,
      S_RE_WALK,
      S_RE_PLACE,
      S_RM_SCAN,
      S_EMIT_EXP,
      S_EMIT_STAT
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_REFUSE,
      DP_INS_STEP,
      DP_INS_PLACE,
      DP_ADV_STEP,
      DP_EXP_STEP,
      DP_IDX_CLR,
      DP_POP,
      DP_RM_STEP,
      DP_EMIT_EXP,
      DP_EMIT_STAT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       full;
      logic       ins_stop;
      logic       adv_done;
      logic       exp_done;
      logic       pop_done;
      logic       head_periodic;
      logic       rm_done;
      logic       emit_done;
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer: steps the datapath through insert, advance, expire, pop,
// remove and result phases.
// ----------------------------------------------------------------------------
`default_nettype none

module dltq_ctrl
   import dltq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  dp_status_type      status,
   output dp_cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = DP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = DP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.func == FUNC_INSERT) begin
               state_in = S_INS_WALK;
            end else begin
               state_in = S_ADV_WALK;
            end
         end
         S_INS_WALK: begin
            if (status.full) begin
               cmd.op   = DP_REFUSE;
               state_in = S_EMIT_STAT;
            end else if (status.ins_stop) begin
               state_in = S_INS_PLACE;
            end else begin
               cmd.op = DP_INS_STEP;
            end
         end
         S_INS_PLACE: begin
            cmd.op   = DP_INS_PLACE;
            state_in = S_EMIT_STAT;
         end
         S_ADV_WALK: begin
            if (status.adv_done) begin
               cmd.op   = DP_IDX_CLR;
               state_in = S_EXP_SCAN;
            end else begin
               cmd.op = DP_ADV_STEP;
            end
         end
         S_EXP_SCAN: begin
            if (status.exp_done) begin
               state_in = S_POP_CHK;
            end else begin
               cmd.op = DP_EXP_STEP;
            end
         end
         S_POP_CHK: begin
            if (status.pop_done) begin
               cmd.op = DP_IDX_CLR;
               if (status.func == FUNC_ADVANCE) begin
                  state_in = S_EMIT_EXP;
               end else begin
                  state_in = S_RM_SCAN;
               end
            end else begin
               cmd.op = DP_POP;
               if (status.head_periodic) begin
                  state_in = S_RE_WALK;
               end
            end
         end
         S_RE_WALK: begin
            if (status.ins_stop) begin
               state_in = S_RE_PLACE;
            end else begin
               cmd.op = DP_INS_STEP;
            end
         end
         S_RE_PLACE: begin
            cmd.op   = DP_INS_PLACE;
            state_in = S_POP_CHK;
         end
         S_RM_SCAN: begin
            if (status.rm_done) begin
               cmd.op   = DP_IDX_CLR;
               state_in = S_EMIT_EXP;
            end else begin
               cmd.op = DP_RM_STEP;
            end
         end
         S_EMIT_EXP: begin
            if (status.emit_done) begin
               state_in = S_EMIT_STAT;
            end else begin
               cmd.op = DP_EMIT_EXP;
            end
         end
         S_EMIT_STAT: begin
            cmd.op   = DP_EMIT_STAT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/dltq_dpath.sv
// ----------------------------------------------------------------------------
// dltq_dpath
// Timer entry storage, walk index, expiry buffer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dltq_dpath
   import dltq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  req_type            req_data,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   logic [31:0] delta_ff  [DEPTH];
   logic [31:0] period_ff [DEPTH];
   logic [7:0]  owner_ff  [DEPTH];
   logic [31:0] value_ff  [DEPTH];
   logic [31:0] delta_in  [DEPTH];
   logic [31:0] period_in [DEPTH];
   logic [7:0]  owner_in  [DEPTH];
   logic [31:0] value_in  [DEPTH];

   // expired entries wait here until the item is finished
   logic [7:0]  ebuf_own_ff [DEPTH];
   logic [31:0] ebuf_val_ff [DEPTH];
   logic [7:0]  ebuf_own_in [DEPTH];
   logic [31:0] ebuf_val_in [DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] ecnt_ff, ecnt_in;
   logic [31:0]      time_ff, time_in;
   logic [31:0]      gone_ff, gone_in;
   logic [31:0]      ins_d_ff, ins_d_in;
   logic [31:0]      ins_p_ff, ins_p_in;
   logic [7:0]       ins_own_ff, ins_own_in;
   logic [31:0]      ins_val_ff, ins_val_in;
   req_type          req_ff, req_in;
   kind_type         kind_ff, kind_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [IDX_W-1:0] idx_lo;
   logic [31:0]      cur_d;
   logic             in_list;
   logic             match;
   logic [31:0]      head_delay;

   assign idx_lo  = idx_ff[IDX_W-1:0];
   assign cur_d   = delta_ff[idx_lo];
   assign in_list = (idx_ff < count_ff);
   assign match   = (owner_ff[idx_lo] == req_ff.owner) &&
                    ((req_ff.func != FUNC_RM_VALUE) || (value_ff[idx_lo] == req_ff.user_value));
   assign head_delay = (count_ff != '0) ? delta_ff[0] : ALL_ONES;

   always_comb begin
      delta_in     = delta_ff;
      period_in    = period_ff;
      owner_in     = owner_ff;
      value_in     = value_ff;
      ebuf_own_in  = ebuf_own_ff;
      ebuf_val_in  = ebuf_val_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      ecnt_in      = ecnt_ff;
      time_in      = time_ff;
      gone_in      = gone_ff;
      ins_d_in     = ins_d_ff;
      ins_p_in     = ins_p_ff;
      ins_own_in   = ins_own_ff;
      ins_val_in   = ins_val_ff;
      req_in       = req_ff;
      kind_in      = kind_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (cmd.op)
         DP_LOAD: begin
            req_in     = req_data;
            idx_in     = '0;
            ecnt_in    = '0;
            gone_in    = req_data.elapsed;
            ins_d_in   = req_data.delay;
            ins_p_in   = req_data.period;
            ins_own_in = req_data.owner;
            ins_val_in = req_data.user_value;
            kind_in    = KIND_DONE;
            if (req_data.func != FUNC_INSERT) begin
               time_in = time_ff + req_data.elapsed;
            end
         end
         DP_REFUSE: begin
            kind_in = KIND_FULL;
         end
         DP_INS_STEP: begin
            ins_d_in = ins_d_ff - cur_d;
            idx_in   = idx_ff + 1'b1;
         end
         DP_INS_PLACE: begin
            for (int j = 1; j < DEPTH; j++) begin
               if (CNT_W'(j) > idx_ff) begin
                  delta_in[j]  = delta_ff[j-1];
                  period_in[j] = period_ff[j-1];
                  owner_in[j]  = owner_ff[j-1];
                  value_in[j]  = value_ff[j-1];
                  if ((CNT_W'(j) == idx_ff + 1'b1) && in_list) begin
                     delta_in[j] = delta_ff[j-1] - ins_d_ff;
                  end
               end
            end
            for (int j = 0; j < DEPTH; j++) begin
               if (CNT_W'(j) == idx_ff) begin
                  delta_in[j]  = ins_d_ff;
                  period_in[j] = ins_p_ff;
                  owner_in[j]  = ins_own_ff;
                  value_in[j]  = ins_val_ff;
               end
            end
            count_in = count_ff + 1'b1;
         end
         DP_ADV_STEP: begin
            if (cur_d < gone_ff) begin
               gone_in          = gone_ff - cur_d;
               delta_in[idx_lo] = '0;
            end else begin
               delta_in[idx_lo] = cur_d - gone_ff;
               gone_in          = '0;
            end
            idx_in = idx_ff + 1'b1;
         end
         DP_EXP_STEP: begin
            ebuf_own_in[ecnt_ff[IDX_W-1:0]] = owner_ff[idx_lo];
            ebuf_val_in[ecnt_ff[IDX_W-1:0]] = value_ff[idx_lo];
            ecnt_in = ecnt_ff + 1'b1;
            idx_in  = idx_ff + 1'b1;
         end
         DP_IDX_CLR: begin
            idx_in = '0;
         end
         DP_POP: begin
            ins_d_in   = period_ff[0];
            ins_p_in   = period_ff[0];
            ins_own_in = owner_ff[0];
            ins_val_in = value_ff[0];
            for (int j = 0; j < DEPTH - 1; j++) begin
               delta_in[j]  = delta_ff[j+1];
               period_in[j] = period_ff[j+1];
               owner_in[j]  = owner_ff[j+1];
               value_in[j]  = value_ff[j+1];
            end
            count_in = count_ff - 1'b1;
            idx_in   = '0;
         end
         DP_RM_STEP: begin
            if (match) begin
               // drop the entry and fold its delta into the one behind it
               for (int j = 0; j < DEPTH - 1; j++) begin
                  if (CNT_W'(j) >= idx_ff) begin
                     delta_in[j]  = delta_ff[j+1];
                     period_in[j] = period_ff[j+1];
                     owner_in[j]  = owner_ff[j+1];
                     value_in[j]  = value_ff[j+1];
                     if ((CNT_W'(j) == idx_ff) && (idx_ff + 1'b1 < count_ff)) begin
                        delta_in[j] = delta_ff[j+1] + delta_ff[j];
                     end
                  end
               end
               count_in = count_ff - 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         DP_EMIT_EXP: begin
            rsp_valid_in       = 1'b1;
            rsp_in.kind        = KIND_EXPIRED;
            rsp_in.owner_out   = ebuf_own_ff[idx_lo];
            rsp_in.value_out   = ebuf_val_ff[idx_lo];
            rsp_in.time_out    = time_ff;
            rsp_in.next_delay  = head_delay;
            rsp_in.entry_count = 5'(count_ff);
            rsp_in.last        = 1'b0;
            idx_in             = idx_ff + 1'b1;
         end
         DP_EMIT_STAT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.kind        = kind_ff;
            rsp_in.owner_out   = '0;
            rsp_in.value_out   = '0;
            rsp_in.time_out    = time_ff;
            rsp_in.next_delay  = head_delay;
            rsp_in.entry_count = 5'(count_ff);
            rsp_in.last        = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff    <= delta_in;
      period_ff   <= period_in;
      owner_ff    <= owner_in;
      value_ff    <= value_in;
      ebuf_own_ff <= ebuf_own_in;
      ebuf_val_ff <= ebuf_val_in;
      idx_ff      <= idx_in;
      ecnt_ff     <= ecnt_in;
      gone_ff     <= gone_in;
      ins_d_ff    <= ins_d_in;
      ins_p_ff    <= ins_p_in;
      ins_own_ff  <= ins_own_in;
      ins_val_ff  <= ins_val_in;
      req_ff      <= req_in;
      kind_ff     <= kind_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      status.func          = req_ff.func;
      status.full          = (count_ff >= CNT_W'(DEPTH));
      status.ins_stop      = !in_list || (ins_d_ff < cur_d);
      status.adv_done      = !in_list || (gone_ff == '0);
      status.exp_done      = !in_list || (cur_d != '0);
      status.pop_done      = (count_ff == '0) || (delta_ff[0] != '0);
      status.head_periodic = (period_ff[0] != '0);
      status.rm_done       = !in_list;
      status.emit_done     = (idx_ff == ecnt_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Sixteen-entry timer list held as relative deltas, with insert, advance,
// remove-by-owner and remove-by-owner-and-value operations.
// ----------------------------------------------------------------------------
// Usage:
//  - A request transaction is taken on a clock edge with start high and
//    busy low; req_data carries func, elapsed, delay, period, owner and
//    user_value.
//  - Each request produces zero or more expiry transactions (kind 0), then
//    one status transaction with rsp_data.last set. Each result is valid for
//    one cycle; the receiver cannot stall, so results are never held.
//  - All results of one request carry the time, head delay and entry count
//    as they stand after the whole request.
//  - The controller walks the list one entry per cycle. Insert walks past
//    the entries ahead of the new delay, then places it; a refused insert
//    goes straight to the status result. Advance applies the elapsed time
//    entry by entry, scans the expired entries into a buffer, pops each
//    expired head and reinserts it if periodic, then emits the expiry
//    results. Remove does the same, then scans the list for matches before
//    the expiry results. All phases share the single entry-walk index.
//  - busy stays high from the accepted request and drops in the cycle the
//    status strobe shows.
//  - Reset (synchronous) empties the list and clears the running time.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_timer_queue
   import dltq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  req_type      req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: one datapath command per cycle
   dltq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // entry storage and result register
   dltq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hw/rtl/dltq_checker.sv
// ----------------------------------------------------------------------------
// dltq_checker
// Port-level checks on the timer queue's request/result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module dltq_checker
   import dltq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input rsp_type      rsp_data
);

   // an accepted request keeps the block busy next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // the status transaction ends the request
   a_last_then_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid)
      else $error("result after final transaction");

   // results other than the last come only while busy
   a_mid_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> busy)
      else $error("expiry result while idle");

   // a refused insert is a lone status result
   a_full_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_FULL) |-> rsp_data.last)
      else $error("refusal not final");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### test/delta_list_timer_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_list_timer_queue_tb
// Self-checking bench for the delta-list timer queue: directed corner
// transactions, then random insert/advance/remove traffic with random
// sender gaps, checked against an in-bench timer list model.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_timer_queue_tb;
   import dltq_pkg::*;

   // Timer list model plus queue of expected result transactions.
   class timer_scoreboard;
      logic [31:0] deltas[$];
      logic [31:0] periods[$];
      logic [7:0]  owners[$];
      logic [31:0] values[$];
      logic [31:0] now;
      rsp_type     pending[$];
      int          errors;
      int          checked;
      int          expiries;

      function new();
         now = 0;
         errors = 0;
         checked = 0;
         expiries = 0;
      endfunction

      // Sorted insert; returns 0 when the list is full.
      function bit place(logic [31:0] d, logic [31:0] p, logic [7:0] o,
                         logic [31:0] v);
         int i;
         if (deltas.size() >= DEPTH) return 0;
         for (i = 0; i < deltas.size(); i++) begin
            if (d < deltas[i]) begin
               deltas[i] = deltas[i] - d;
               break;
            end
            d = d - deltas[i];
         end
         deltas.insert(i, d);
         periods.insert(i, p);
         owners.insert(i, o);
         values.insert(i, v);
         return 1;
      endfunction

      function void drop(int i);
         deltas.delete(i);
         periods.delete(i);
         owners.delete(i);
         values.delete(i);
      endfunction

      // Note an accepted request and queue the results it must cause.
      function void note_request(req_type rq);
         rsp_type     outs[$];
         rsp_type     r;
         kind_type    k;
         logic [31:0] gone;
         logic [31:0] p, v;
         logic [7:0]  o;
         int          i;
         k = KIND_DONE;
         if (rq.func == FUNC_INSERT) begin
            if (!place(rq.delay, rq.period, rq.owner, rq.user_value)) k = KIND_FULL;
         end else begin
            now = now + rq.elapsed;
            gone = rq.elapsed;
            for (i = 0; i < deltas.size() && gone > 0; i++) begin
               if (deltas[i] < gone) begin
                  gone = gone - deltas[i];
                  deltas[i] = 0;
               end else begin
                  deltas[i] = deltas[i] - gone;
                  gone = 0;
               end
            end
            for (i = 0; i < deltas.size() && deltas[i] == 0; i++) begin
               r = '0;
               r.kind = KIND_EXPIRED;
               r.owner_out = owners[i];
               r.value_out = values[i];
               outs.push_back(r);
            end
            while (deltas.size() > 0 && deltas[0] == 0) begin
               p = periods[0];
               o = owners[0];
               v = values[0];
               drop(0);
               if (p > 0) void'(place(p, p, o, v));
            end
            if (rq.func != FUNC_ADVANCE) begin
               i = 0;
               while (i < deltas.size()) begin
                  if (owners[i] == rq.owner &&
                      (rq.func == FUNC_RM_OWNER || values[i] == rq.user_value)) begin
                     if (i + 1 < deltas.size()) deltas[i+1] = deltas[i+1] + deltas[i];
                     drop(i);
                  end else begin
                     i++;
                  end
               end
            end
         end
         r = '0;
         r.kind = k;
         outs.push_back(r);
         foreach (outs[j]) begin
            outs[j].time_out = now;
            outs[j].next_delay = deltas.size() > 0 ? deltas[0] : ALL_ONES;
            outs[j].entry_count = 5'(deltas.size());
            outs[j].last = (j == outs.size() - 1);
            pending.push_back(outs[j]);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, exp none got %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.kind == KIND_EXPIRED) expiries++;
         if (got.kind !== want.kind)
            $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
         if (got.owner_out !== want.owner_out)
            $display("%0t: owner exp %h got %h", $time, want.owner_out, got.owner_out);
         if (got.value_out !== want.value_out)
            $display("%0t: value exp %h got %h", $time, want.value_out, got.value_out);
         if (got.time_out !== want.time_out)
            $display("%0t: time exp %h got %h", $time, want.time_out, got.time_out);
         if (got.next_delay !== want.next_delay)
            $display("%0t: next_delay exp %h got %h", $time, want.next_delay,
                     got.next_delay);
         if (got.entry_count !== want.entry_count)
            $display("%0t: count exp %0d got %0d", $time, want.entry_count,
                     got.entry_count);
         if (got.last !== want.last)
            $display("%0t: last exp %b got %b", $time, want.last, got.last);
         if (got !== want) errors++;
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   timer_scoreboard sb;
   int      idle_cycles;
   int      sent;
   bit      gaps_on;

   delta_list_timer_queue u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Monitor: results, accepted requests and the no-progress watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_data);
         if (start && !busy) sb.note_request(req_data);
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Present one transaction and hold it until accepted.
   task automatic send(req_type rq);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type mk(logic [1:0] f, logic [31:0] el, logic [31:0] d,
                                  logic [31:0] p, logic [7:0] o, logic [31:0] v);
      req_type rq;
      rq.func = f;
      rq.elapsed = el;
      rq.delay = d;
      rq.period = p;
      rq.owner = o;
      rq.user_value = v;
      return rq;
   endfunction

   // Random transaction; small owner and delay pools make hits likely.
   function automatic req_type rand_req();
      req_type rq;
      int      sel;
      rq = mk(2'($urandom_range(0, 3)), $urandom_range(0, 40), $urandom_range(0, 60),
              $urandom_range(0, 2) == 0 ? $urandom_range(1, 30) : 0,
              8'($urandom_range(0, 5)), $urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      if (sel == 0) rq = mk(2'($urandom), $urandom, $urandom, $urandom, 8'($urandom),
                            $urandom);
      else if (sel < 5) rq.func = FUNC_INSERT;
      return rq;
   endfunction

   initial begin
      sb = new();
      reset = 1;
      start = 0;
      req_data = '0;
      idle_cycles = 0;
      gaps_on = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty advance, inserts incl. zero and max delay, ties.
      send(mk(FUNC_ADVANCE, 0, 0, 0, 0, 0));
      send(mk(FUNC_INSERT, 0, 10, 0, 8'h01, 32'h1111_1111));
      send(mk(FUNC_INSERT, 0, 10, 0, 8'h02, 32'h2222_2222));
      send(mk(FUNC_INSERT, 0, 5, 7, 8'h03, 32'h3333_3333));
      send(mk(FUNC_INSERT, 0, ALL_ONES, ALL_ONES, 8'hFF, ALL_ONES));
      send(mk(FUNC_INSERT, 0, 0, 0, 8'h00, 0));
      send(mk(FUNC_ADVANCE, 0, 0, 0, 0, 0));        // zero elapsed, head expires
      send(mk(FUNC_ADVANCE, 5, 0, 0, 0, 0));        // periodic expiry
      send(mk(FUNC_RM_VALUE, 1, 0, 0, 8'h02, 32'h2222_2222));
      send(mk(FUNC_RM_OWNER, 0, 0, 0, 8'h77, 0));   // no match
      send(mk(FUNC_RM_OWNER, 2, 0, 0, 8'h03, 0));
      send(mk(FUNC_ADVANCE, ALL_ONES, 0, 0, 0, 0)); // all expire, time wraps
      for (int i = 0; i < DEPTH + 1; i++)           // fill, then refused
         send(mk(FUNC_INSERT, 0, i * 3, i % 4, 8'(i % 3), i));
      send(mk(FUNC_ADVANCE, 100, 0, 0, 0, 0));
      send(mk(FUNC_RM_OWNER, 0, 0, 0, 8'h00, 0));
      send(mk(FUNC_RM_OWNER, 0, 0, 0, 8'h01, 0));
      send(mk(FUNC_RM_OWNER, 0, 0, 0, 8'h02, 0));

      // Hold off until the queue drains.
      while (sb.pending.size() > 0) @(posedge clock);

      for (sent = 0; sent < 90; sent++) begin
         if (sent >= 75) gaps_on = 0;
         send(rand_req());
      end

      while (sb.pending.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("Checked %0d results (%0d expiries) from directed and random traffic.",
               sb.checked, sb.expiries);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
hw/rtl/dltq_pkg.sv
hw/rtl/dltq_ctrl.sv
hw/rtl/dltq_dpath.sv
hw/rtl/delta_list_timer_queue.sv
hw/rtl/dltq_checker.sv
test/delta_list_timer_queue_tb.sv
